/* rtl/core/tli_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and state encodings for the table interpolator.
// No dependencies; compile first.
package tli_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int CW          = $clog2(TABLE_DEPTH + 1);
  localparam int DW          = 32;
  localparam int SEG_W       = 9;
  localparam int PT_W        = 2 * DW;
  localparam int PROD_W      = 2 * DW;
  // quotient bits kept; anything at or above 2^QW saturates
  localparam int QW          = 35;
  localparam int HI_W        = PROD_W - QW;
  localparam int ITER_W      = $clog2(QW + 1);
  localparam int SUM_W       = QW + 1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_ZERO_SPAN = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
  } point_t;

  typedef struct packed {
    point_t               lo;
    point_t               hi;
    logic signed [DW-1:0] q;
  } lerp_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SEEK,
    S_CMP,
    S_EVAL,
    S_RD_HI,
    S_RD_LO,
    S_ARITH,
    S_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_PRE,
    A_DIV,
    A_FIN
  } arith_state_t;

endpackage

/* rtl/core/tli_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input word, result word, configuration word.
// Depends on tli_pkg for field widths.
interface tli_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic                         new_run;
  logic signed [tli_pkg::DW-1:0] point_x;
  logic signed [tli_pkg::DW-1:0] point_y;
  logic signed [tli_pkg::DW-1:0] query_x;

  modport source(output valid, func, new_run, point_x, point_y, query_x, input ready);
  modport sink(input valid, func, new_run, point_x, point_y, query_x, output ready);
endinterface

interface tli_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [tli_pkg::DW-1:0] interp_value;
  logic [1:0]                   status;
  logic [tli_pkg::SEG_W-1:0]    segment;

  modport source(output valid, interp_value, status, segment, input ready);
  modport sink(input valid, interp_value, status, segment, output ready);
endinterface

interface tli_cfg_if;
  logic valid;
  logic ready;
  logic decreasing;

  modport source(output valid, decreasing, input ready);
  modport sink(input valid, decreasing, output ready);
endinterface

/* rtl/core/tli_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module tli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/tli_lerp.sv */
`timescale 1ns / 1ps
// Interpolation arithmetic: 32x32 multiply, then a bit-per-cycle restoring
// divider with early saturation, then the signed add and clamp. Uses tli_pkg.
module tli_lerp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  tli_pkg::lerp_req_t            req,
  output logic                          done,
  output logic signed [tli_pkg::DW-1:0] result
);
  import tli_pkg::*;

  arith_state_t state_r, state_nxt;

  logic [DW-1:0]         ady_r, adq_r, adx_r;
  logic                  neg_r;
  logic signed [DW-1:0]  y1_r;
  logic [PROD_W-1:0]     prod_r;
  logic [DW-1:0]         rem_r;
  logic [QW-1:0]         dvd_r;
  logic [ITER_W-1:0]     iter_r;
  logic                  sat_r;

  logic signed [DW:0]    dy, dq, dx;
  logic                  pre_sat;
  logic [DW+1:0]         trial;
  logic                  ge;
  logic                  big;
  logic signed [SUM_W-1:0] y1_ext, quo_ext, sum;
  logic                  ovf;

  function automatic logic [DW-1:0] mag(input logic signed [DW:0] v);
    logic signed [DW:0] a;
    a = v[DW] ? -v : v;
    return a[DW-1:0];
  endfunction

  assign dy = {req.hi.y[DW-1], req.hi.y} - {req.lo.y[DW-1], req.lo.y};
  assign dq = {req.q[DW-1], req.q}       - {req.lo.x[DW-1], req.lo.x};
  assign dx = {req.hi.x[DW-1], req.hi.x} - {req.lo.x[DW-1], req.lo.x};

  // quotient reaches 2^QW exactly when the top product bits reach the divisor
  assign pre_sat = {{(DW-HI_W){1'b0}}, prod_r[PROD_W-1:QW]} >= adx_r;

  // shared subtractor for every divide step
  assign trial = {1'b0, rem_r, dvd_r[QW-1]} - {2'b00, adx_r};
  assign ge    = !trial[DW+1];

  assign big     = dvd_r[QW-1] && (|dvd_r[QW-2:0]);
  assign y1_ext  = SUM_W'(y1_r);
  assign quo_ext = $signed({1'b0, dvd_r});
  assign sum     = neg_r ? (y1_ext - quo_ext) : (y1_ext + quo_ext);
  assign ovf     = !((&sum[SUM_W-1:DW-1]) || !(|sum[SUM_W-1:DW-1]));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      A_IDLE: if (start) state_nxt = A_MUL;
      A_MUL:  state_nxt = A_PRE;
      A_PRE:  state_nxt = pre_sat ? A_FIN : A_DIV;
      A_DIV:  if (iter_r == ITER_W'(1)) state_nxt = A_FIN;
      A_FIN:  state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done   = (state_r == A_FIN);
    result = sum[DW-1:0];
    if (sat_r || big) begin
      result = neg_r ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else if (ovf) begin
      result = sum[SUM_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      A_IDLE: begin
        if (start) begin
          ady_r <= mag(dy);
          adq_r <= mag(dq);
          adx_r <= mag(dx);
          neg_r <= dy[DW] ^ dq[DW] ^ dx[DW];
          y1_r  <= req.lo.y;
        end
      end
      A_MUL: begin
        prod_r <= ady_r * adq_r;
      end
      A_PRE: begin
        sat_r  <= pre_sat;
        rem_r  <= DW'(prod_r[PROD_W-1:QW]);
        dvd_r  <= prod_r[QW-1:0];
        iter_r <= ITER_W'(QW);
      end
      A_DIV: begin
        rem_r  <= ge ? trial[DW-1:0] : {rem_r[DW-2:0], dvd_r[QW-1]};
        dvd_r  <= {dvd_r[QW-2:0], ge};
        iter_r <= iter_r - ITER_W'(1);
      end
      A_FIN: begin
        sat_r <= sat_r;
      end
      default: begin
        sat_r <= sat_r;
      end
    endcase
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == A_IDLE)
    else $error("lerp unit started while busy");
`endif

endmodule

/* rtl/core/table_linear_interpolator.sv */
`timescale 1ns / 1ps
// Top level of the piecewise-linear table interpolator: sequencer, cursor,
// point count and output register. Uses tli_pkg, tli_ifs, tli_ram, tli_lerp.
//
// Usage:
//   in_ch  : one word per request. func = load stores (point_x, point_y) at
//            the end of the table (new_run empties the table first); func =
//            query interpolates at query_x (new_run rewinds the cursor first).
//   out_ch : exactly one word per request: interp_value (Q16.16), status
//            (ok, out of range, zero-width segment, table full) and segment,
//            the cursor after a query (zero for loads).
//   cfg_ch : one-bit word that selects increasing or decreasing tables; write
//            it only while no request is in flight. It is always ready.
// Flow: in_ready is high only in idle, so one request is in flight at a
//   time. A load passes the load state, then the output state. A query
//   does one RAM read and one compare per table entry the cursor steps
//   past; to interpolate it reads both breakpoints, then runs the 35-step
//   restoring divider in the arithmetic unit unless the quotient saturates
//   early. A query outside the table skips the breakpoint reads.
// Stall: a finished word waits in the output register; the next request is
//   accepted meanwhile and finishes up to that register, then holds.
// Reset: empties the table (count and cursor go to zero), clears the
//   configuration bit and the output valid flag. No RAM clearing pass.
module table_linear_interpolator (
  input  logic      clk,
  input  logic      rst_n,
  tli_in_if.sink    in_ch,
  tli_out_if.source out_ch,
  tli_cfg_if.sink   cfg_ch
);
  import tli_pkg::*;

  ctl_state_t state_r, state_nxt;

  logic                  dec_r;
  logic                  func_r;
  logic signed [DW-1:0]  px_r, py_r, q_r;
  logic [CW-1:0]         count_r, cursor_r;
  point_t                hi_r;

  // finished word waiting for the output register
  logic signed [DW-1:0]  rv_r;
  status_t               rs_r;

  logic                  ov_r;
  logic signed [DW-1:0]  oval_r;
  status_t               ostat_r;
  logic [SEG_W-1:0]      oseg_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  full;
  logic                  in_tbl;
  logic                  advance;
  logic                  bad_seg;
  logic [CW-1:0]         cur_m1;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [PT_W-1:0]       ram_rdata;
  point_t                rd_pt;
  point_t                wr_pt;

  logic                  lerp_start, lerp_done;
  lerp_req_t             lerp_req;
  logic signed [DW-1:0]  lerp_result;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;
  assign full     = (count_r == CW'(TABLE_DEPTH));
  assign in_tbl   = (cursor_r < count_r);
  assign rd_pt    = point_t'(ram_rdata);
  assign cur_m1   = cursor_r - CW'(1);
  // keep stepping while the query is at or past the breakpoint
  assign advance  = dec_r ? (q_r <= rd_pt.x) : (q_r >= rd_pt.x);
  assign bad_seg  = (cursor_r == '0) || !in_tbl;

  assign wr_pt.x  = px_r;
  assign wr_pt.y  = py_r;

  assign lerp_req.lo = rd_pt;
  assign lerp_req.hi = hi_r;
  assign lerp_req.q  = q_r;

  tli_ram #(
    .WIDTH(PT_W),
    .DEPTH(TABLE_DEPTH)
  ) u_tbl (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_pt),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tli_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .req   (lerp_req),
    .done  (lerp_done),
    .result(lerp_result)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = (in_ch.func == FUNC_LOAD) ? S_LOAD : S_SEEK;
      S_LOAD:  state_nxt = S_OUT;
      S_SEEK:  state_nxt = in_tbl ? S_CMP : S_EVAL;
      S_CMP:   state_nxt = advance ? S_SEEK : S_EVAL;
      S_EVAL:  state_nxt = bad_seg ? S_OUT : S_RD_HI;
      S_RD_HI: state_nxt = S_RD_LO;
      S_RD_LO: state_nxt = (rd_pt.x == hi_r.x) ? S_OUT : S_ARITH;
      S_ARITH: if (lerp_done) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    ram_we      = 1'b0;
    ram_waddr   = count_r[AW-1:0];
    ram_re      = 1'b0;
    ram_raddr   = cursor_r[AW-1:0];
    lerp_start  = 1'b0;
    unique case (state_r)
      S_LOAD:  ram_we = !full;
      S_SEEK:  ram_re = in_tbl;
      S_EVAL:  ram_re = !bad_seg;
      S_RD_HI: begin
        ram_re    = 1'b1;
        ram_raddr = cur_m1[AW-1:0];
      end
      S_RD_LO: lerp_start = (rd_pt.x != hi_r.x);
      default: ram_re = 1'b0;
    endcase
  end

  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = ov_r;
  assign out_ch.interp_value = oval_r;
  assign out_ch.status       = ostat_r;
  assign out_ch.segment      = oseg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      dec_r <= cfg_ch.decreasing;
    end
  end

  // count and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.new_run) begin
            cursor_r <= '0;
            if (in_ch.func == FUNC_LOAD) begin
              count_r <= '0;
            end
          end
        end
        S_LOAD: if (!full) count_r <= count_r + CW'(1);
        S_CMP:  if (advance) cursor_r <= cursor_r + CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // request fields, upper breakpoint and finished word
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_r <= in_ch.func;
          px_r   <= in_ch.point_x;
          py_r   <= in_ch.point_y;
          q_r    <= in_ch.query_x;
        end
      end
      S_LOAD: begin
        rv_r <= '0;
        rs_r <= full ? ST_FULL : ST_OK;
      end
      S_EVAL: begin
        rv_r <= '0;
        rs_r <= ST_RANGE;
      end
      S_RD_HI: hi_r <= rd_pt;
      S_RD_LO: begin
        rv_r <= '0;
        rs_r <= ST_ZERO_SPAN;
      end
      S_ARITH: begin
        rv_r <= lerp_result;
        rs_r <= ST_OK;
      end
      default: hi_r <= hi_r;
    endcase
  end

  // output register: hold until taken, refill from the finished word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      oval_r  <= rv_r;
      ostat_r <= rs_r;
      oseg_r  <= (func_r == FUNC_QUERY) ? SEG_W'(cursor_r) : '0;
    end
  end

`ifndef SYNTH
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r)
    else $error("search cursor beyond point count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("point count beyond table depth");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_LOAD) && !full)
    else $error("table write without room");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("new word accepted while busy");
`endif

endmodule

/* dv/table_linear_interpolator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for table_linear_interpolator: random and directed
// load/query words, a built-in table predictor and a word-by-word result check.
// Depends on tli_pkg and tli_ifs from the RTL.
module table_linear_interpolator_tb;
  import tli_pkg::*;

  // Abort after this many cycles with no handshake on any channel. The
  // slowest query walks all entries, and this limit covers that query
  // plus the long receiver hold several times over.
  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 400;   // cycles the receiver holds off once
  localparam int HOLD_AT      = 150;   // input words accepted before that hold
  localparam int SETTLE       = 6;     // pause before a configuration write
  localparam int DRAIN_CYCLES = 60;    // quiet cycles checked at the end
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 100;
  localparam int FULL_PHASE   = 3;
  localparam int MAX_REPORTS  = 100;

  localparam longint S32_MAX_L = 64'sd2147483647;
  localparam longint S32_MIN_L = -64'sd2147483648;
  localparam logic signed [DW-1:0] V_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] V_MIN = 32'sh8000_0000;

  typedef struct {
    logic                 func;
    logic                 new_run;
    logic signed [DW-1:0] px;
    logic signed [DW-1:0] py;
    logic signed [DW-1:0] qx;
  } req_word_t;

  typedef struct {
    logic signed [DW-1:0] value;
    status_t              status;
    logic [SEG_W-1:0]     segment;
  } result_word_t;

  logic clk;
  logic rst_n;

  tli_in_if  in_ch ();
  tli_out_if out_ch ();
  tli_cfg_if cfg_ch ();

  table_linear_interpolator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Table predictor: own copy of the breakpoints, count, cursor and mode.
  logic signed [DW-1:0] tbl_x [TABLE_DEPTH];
  logic signed [DW-1:0] tbl_y [TABLE_DEPTH];
  int unsigned          tbl_count;
  int unsigned          tbl_cursor;
  logic                 decreasing_mode;

  req_word_t    words_to_send [$];    // stimulus not yet on the bus
  result_word_t pending_results [$];  // predicted results, oldest first

  int  tx_idle_pct;
  int  rx_idle_pct;
  int  queued_words;
  int  words_accepted;
  int  results_seen;
  int  mismatch_count;
  int  idle_cycles;
  int  hold_left;
  bit  long_hold_done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Y1 + DY*DQ/DX with the product exact, the quotient truncated toward zero
  // and the sum saturated to 32 bits. Huge quotients saturate right away.
  function automatic logic signed [DW-1:0] lerp_q16(longint x1, longint y1, longint x2,
                                                    longint y2, longint q);
    longint    dy, dq, dx, sum;
    bit [63:0] ady, adq, adx, quo;
    bit        neg;
    dy  = y2 - y1;
    dq  = q - x1;
    dx  = x2 - x1;
    ady = (dy < 0) ? -dy : dy;
    adq = (dq < 0) ? -dq : dq;
    adx = (dx < 0) ? -dx : dx;
    neg = (dy < 0) ^ (dq < 0) ^ (dx < 0);
    quo = (ady * adq) / adx;
    if (quo > (64'd1 << 34))
      return neg ? V_MIN : V_MAX;
    sum = neg ? y1 - longint'(quo) : y1 + longint'(quo);
    if (sum > S32_MAX_L) sum = S32_MAX_L;
    if (sum < S32_MIN_L) sum = S32_MIN_L;
    return sum[DW-1:0];
  endfunction

  // Apply one accepted word to the predicted table and return its result.
  function automatic result_word_t table_step(req_word_t w);
    result_word_t r;
    r.value   = '0;
    r.status  = ST_OK;
    r.segment = '0;
    if (w.func == FUNC_LOAD) begin
      if (w.new_run) begin
        tbl_count  = 0;
        tbl_cursor = 0;
      end
      if (tbl_count >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        tbl_x[tbl_count] = w.px;
        tbl_y[tbl_count] = w.py;
        tbl_count++;
      end
    end else begin
      if (w.new_run) tbl_cursor = 0;
      // advance the cursor only forward, never beyond the point count
      while (tbl_cursor < tbl_count &&
             (decreasing_mode ? (w.qx <= tbl_x[tbl_cursor]) : (w.qx >= tbl_x[tbl_cursor])))
        tbl_cursor++;
      r.segment = SEG_W'(tbl_cursor);
      if (tbl_cursor == 0 || tbl_cursor >= tbl_count)
        r.status = ST_RANGE;
      else if (tbl_x[tbl_cursor-1] == tbl_x[tbl_cursor])
        r.status = ST_ZERO_SPAN;
      else
        r.value = lerp_q16(tbl_x[tbl_cursor-1], tbl_y[tbl_cursor-1], tbl_x[tbl_cursor],
                           tbl_y[tbl_cursor], w.qx);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic longint rand_s32();
    return longint'(int'($urandom));
  endfunction

  function automatic logic [DW-1:0] rand_word();
    return $urandom;
  endfunction

  // uniform in [0, span-1], span > 0
  function automatic longint rand_below(longint span);
    return longint'({$urandom, $urandom} >> 1) % span;
  endfunction

  function automatic logic [DW-1:0] rand_ordinate();
    if ($urandom_range(1)) return $urandom;
    return DW'(rand_s32() >>> $urandom_range(4, 24));
  endfunction

  // Sequences are built on an increasing axis; flip it bitwise for
  // decreasing tables, which reverses the order without any overflow.
  function automatic logic [DW-1:0] to_axis(longint u, bit desc);
    logic [DW-1:0] v;
    v = u[DW-1:0];
    return desc ? ~v : v;
  endfunction

  task automatic queue_word(logic func, logic new_run, logic [DW-1:0] px,
                            logic [DW-1:0] py, logic [DW-1:0] qx);
    req_word_t w;
    w.func    = func;
    w.new_run = new_run;
    w.px      = px;
    w.py      = py;
    w.qx      = qx;
    words_to_send.push_back(w);
    queued_words++;
  endtask

  // Empty table, extreme abscissas and ordinates, equal neighbors, a stale
  // cursor that drives the sum into saturation, a zero-width segment reached
  // by loading behind the cursor, and queries below and above the table.
  task automatic queue_directed_increasing();
    queue_word(FUNC_QUERY, 1'b1, rand_word(), rand_word(), '0);
    queue_word(FUNC_LOAD,  1'b1, V_MIN, V_MAX, rand_word());
    queue_word(FUNC_LOAD,  1'b0, '0, V_MIN, rand_word());
    queue_word(FUNC_LOAD,  1'b0, '0, 32'sd5, rand_word());
    queue_word(FUNC_LOAD,  1'b0, V_MAX, V_MAX, rand_word());
    queue_word(FUNC_QUERY, 1'b1, rand_word(), rand_word(), V_MIN);
    queue_word(FUNC_QUERY, 1'b0, rand_word(), rand_word(), -32'sd1);
    queue_word(FUNC_QUERY, 1'b0, rand_word(), rand_word(), '0);
    queue_word(FUNC_QUERY, 1'b0, rand_word(), rand_word(), V_MAX);
    queue_word(FUNC_LOAD,  1'b1, 32'sd10, '0, rand_word());
    queue_word(FUNC_LOAD,  1'b0, 32'sd11, V_MAX, rand_word());
    queue_word(FUNC_LOAD,  1'b0, 32'sd1000, V_MIN, rand_word());
    queue_word(FUNC_QUERY, 1'b1, rand_word(), rand_word(), 32'sd100);
    queue_word(FUNC_QUERY, 1'b0, rand_word(), rand_word(), V_MIN);
    queue_word(FUNC_QUERY, 1'b0, rand_word(), rand_word(), 32'sd5000);
    queue_word(FUNC_LOAD,  1'b0, 32'sd1000, 32'sd7, rand_word());
    queue_word(FUNC_QUERY, 1'b0, rand_word(), rand_word(), 32'sd500);
    queue_word(FUNC_QUERY, 1'b1, rand_word(), rand_word(), 32'sd9);
  endtask

  task automatic queue_directed_decreasing();
    queue_word(FUNC_LOAD,  1'b1, V_MAX, 32'sh0001_0000, rand_word());
    queue_word(FUNC_LOAD,  1'b0, '0, 32'shFFFF_0000, rand_word());
    queue_word(FUNC_LOAD,  1'b0, V_MIN, V_MAX, rand_word());
    queue_word(FUNC_QUERY, 1'b1, rand_word(), rand_word(), V_MAX);
    queue_word(FUNC_QUERY, 1'b0, rand_word(), rand_word(), 32'sh0000_8000);
    queue_word(FUNC_QUERY, 1'b0, rand_word(), rand_word(), -32'sd12345);
    queue_word(FUNC_QUERY, 1'b0, rand_word(), rand_word(), V_MIN);
  endtask

  // One table of n_pts monotone points, then n_qry mostly monotone queries.
  // Clear fresh to append to whatever table is already loaded.
  task automatic queue_table_sequence(bit desc, int n_pts, int n_qry, bit fresh);
    longint pts [$];
    longint u, room, uq, hi;
    int     i, j, r;
    r = $urandom_range(7);
    u = (r == 0) ? S32_MIN_L : (rand_s32() >>> $urandom_range(0, 8));
    for (i = 0; i < n_pts; i++) begin
      if (i > 0) begin
        room = (S32_MAX_L - u) / (n_pts - i);
        r = $urandom_range(7);
        // r == 0 repeats the abscissa and makes a zero-width segment
        if (r != 0 && room > 0) begin
          if (r == 1)
            u += 1 + rand_below((room < 4) ? room : 4);
          else if (r < 5)
            u += 1 + rand_below((room < (1 << 20)) ? room : (1 << 20));
          else
            u += 1 + rand_below(room);
        end
      end
      pts.push_back(u);
      queue_word(FUNC_LOAD, (i == 0) && fresh, to_axis(u, desc), rand_ordinate(), rand_word());
    end
    uq = (n_pts > 0) ? pts[0] - longint'($urandom_range(0, 3)) : rand_s32();
    for (j = 0; j < n_qry; j++) begin
      if (uq < S32_MIN_L) uq = S32_MIN_L;
      hi = (n_pts > 0) ? pts[n_pts-1] + 1 : S32_MAX_L;
      if (hi > S32_MAX_L) hi = S32_MAX_L;
      r = $urandom_range(9);
      if (r == 0)
        uq = rand_s32();
      else if (r == 1 && n_pts > 0)
        uq = pts[$urandom_range(n_pts - 1)];
      else if (r == 2)
        uq = $urandom_range(1) ? S32_MIN_L : S32_MAX_L;
      else if (hi > uq)
        uq += rand_below(hi - uq + 1) / $urandom_range(1, 4);
      queue_word(FUNC_QUERY, (j == 0) || ($urandom_range(9) == 0), rand_word(), rand_word(),
                 to_axis(uq, desc));
    end
  endtask

  // Fill every entry, overrun it with loads that must report a full table,
  // then walk the whole table and long stretches of it.
  task automatic queue_full_table(bit desc);
    int i;
    for (i = 0; i < TABLE_DEPTH + 3; i++)
      queue_word(FUNC_LOAD, i == 0, to_axis(longint'(i - 128) <<< 20, desc), rand_word(),
                 rand_word());
    queue_word(FUNC_QUERY, 1'b1, rand_word(), rand_word(), to_axis(S32_MAX_L, desc));
    queue_word(FUNC_QUERY, 1'b1, rand_word(), rand_word(),
               to_axis((longint'(100 - 128) <<< 20) + 5, desc));
    queue_word(FUNC_QUERY, 1'b0, rand_word(), rand_word(),
               to_axis((longint'(250 - 128) <<< 20) + 7, desc));
  endtask

  // Mostly well-formed tables with random content; a fifth is raw noise and
  // a tenth of the tables runs against the configured direction.
  task automatic queue_random_phase(bit with_full_table);
    int start;
    start = queued_words;
    if (with_full_table) queue_full_table(decreasing_mode);
    while (queued_words - start < PHASE_WORDS) begin
      if ($urandom_range(9) < 2) begin
        repeat ($urandom_range(1, 3))
          queue_word(1'($urandom_range(1)), 1'($urandom_range(1)), rand_word(), rand_word(),
                     rand_word());
      end else begin
        queue_table_sequence(($urandom_range(9) == 0) ? !decreasing_mode : decreasing_mode,
                             ($urandom_range(3) == 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(2, 12),
                             $urandom_range(1, 8), $urandom_range(9) != 0);
      end
    end
  endtask

  // Write the mode register; the predictor follows at the handshake.
  task automatic write_decreasing(logic mode);
    @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.decreasing <= mode;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    decreasing_mode = mode;
    cfg_ch.valid   <= 1'b0;
  endtask

  // Hold until every queued word went in and every result came back.
  task automatic wait_until_drained();
    while (words_to_send.size() != 0 || in_ch.valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: predict each accepted word, then offer the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_words
    req_word_t seen;
    req_word_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen.func    = in_ch.func;
        seen.new_run = in_ch.new_run;
        seen.px      = in_ch.point_x;
        seen.py      = in_ch.point_y;
        seen.qx      = in_ch.query_x;
        pending_results.push_back(table_step(seen));
        words_accepted++;
      end
      // change the bus only when the current word is gone or none is offered
      if (!in_ch.valid || in_ch.ready) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = words_to_send.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.func    <= nxt.func;
          in_ch.new_run <= nxt.new_run;
          in_ch.point_x <= nxt.px;
          in_ch.point_y <= nxt.py;
          in_ch.query_x <= nxt.qx;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: check each word against the oldest prediction and drive
  // ready, with one long hold-off so the block backs up into its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result word %0d arrived with nothing expected",
                                  results_seen));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.interp_value !== want.value)
            flag_mismatch($sformatf("word %0d interp_value %h, expected %h", results_seen,
                                    out_ch.interp_value, want.value));
          if (out_ch.status !== want.status)
            flag_mismatch($sformatf("word %0d status %0d, expected %0d", results_seen,
                                    out_ch.status, want.status));
          if (out_ch.segment !== want.segment)
            flag_mismatch($sformatf("word %0d segment %0d, expected %0d", results_seen,
                                    out_ch.segment, want.segment));
        end
      end
      if (!long_hold_done && words_accepted >= HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: give up when no channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** table_linear_interpolator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Run: reset, then phases that alternate the table direction. Idling goes
  // sender-light/receiver-heavy, then the reverse, then none at all.
  // ---------------------------------------------------------------------------
  initial begin : run_phases
    int phase;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_LOAD;
    in_ch.new_run     = 1'b0;
    in_ch.point_x     = '0;
    in_ch.point_y     = '0;
    in_ch.query_x     = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.decreasing = 1'b0;
    decreasing_mode   = 1'b0;
    tbl_count         = 0;
    tbl_cursor        = 0;
    tx_idle_pct       = 30;
    rx_idle_pct       = 77;
    queued_words      = 0;
    words_accepted    = 0;
    results_seen      = 0;
    mismatch_count    = 0;
    idle_cycles       = 0;
    hold_left         = 0;
    long_hold_done    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < 4) begin
        tx_idle_pct = 30;
        rx_idle_pct = 77;
      end else if (phase < 6) begin
        tx_idle_pct = 77;
        rx_idle_pct = 30;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_decreasing(phase[0]);
      if (phase == 0)
        queue_directed_increasing();
      else if (phase == 1)
        queue_directed_decreasing();
      else
        queue_random_phase(phase == FULL_PHASE);
      wait_until_drained();
    end

    // check that nothing else comes out once the block has gone quiet
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d expected result words never arrived",
                              pending_results.size()));
    if (mismatch_count == 0) begin
      $display("** table_linear_interpolator: PASSED **");
    end else begin
      $display("** table_linear_interpolator: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/tli_pkg.sv
rtl/core/tli_ifs.sv
rtl/core/tli_ram.sv
rtl/core/tli_lerp.sv
rtl/core/table_linear_interpolator.sv
dv/table_linear_interpolator_tb.sv
